// ===== hdl/opbb_pkg.sv =====
// Shared types, shape tables and helpers for the opaque pixel bounding box block.
package opbb_pkg;

  localparam int unsigned NumCodes  = 12;
  localparam int unsigned PixW      = 8;
  localparam int unsigned PixPerRow = 8;
  localparam int unsigned RowW      = PixW * PixPerRow;
  localparam int unsigned OutDataW  = 32;

  typedef logic [3:0] size_code_t;
  typedef logic [6:0] dim_t;

  localparam dim_t ShapeW [NumCodes] = '{
    7'd8, 7'd16, 7'd32, 7'd64, 7'd16, 7'd32, 7'd32, 7'd64, 7'd8, 7'd8, 7'd16, 7'd32
  };
  localparam dim_t ShapeH [NumCodes] = '{
    7'd8, 7'd16, 7'd32, 7'd64, 7'd8, 7'd8, 7'd16, 7'd32, 7'd16, 7'd32, 7'd32, 7'd64
  };

  // Summary of one tile row: any opaque pixel, first and last opaque column.
  typedef struct packed {
    logic       any;
    logic [2:0] first;
    logic [2:0] last;
  } row_scan_t;

  // Unused codes fall back to the 8x8 shape.
  function automatic dim_t sprite_w(size_code_t code);
    dim_t w;
    w = ShapeW[0];
    if (code < 4'(NumCodes)) w = ShapeW[code];
    return w;
  endfunction

  function automatic dim_t sprite_h(size_code_t code);
    dim_t h;
    h = ShapeH[0];
    if (code < 4'(NumCodes)) h = ShapeH[code];
    return h;
  endfunction

endpackage

// ===== hdl/opbb_row_scan.sv =====
// Per-row opaque pixel scan: flags nonzero bytes and finds first/last opaque column.
module opbb_row_scan (
  input  logic [opbb_pkg::RowW-1:0] row_i,
  output opbb_pkg::row_scan_t       scan_o
);

  logic [opbb_pkg::PixPerRow-1:0] opaque;

  always_comb begin
    for (int k = 0; k < opbb_pkg::PixPerRow; k++) begin
      opaque[k] = |row_i[k*opbb_pkg::PixW +: opbb_pkg::PixW];
    end
  end

  always_comb begin
    scan_o.any   = |opaque;
    scan_o.first = 3'd0;
    scan_o.last  = 3'd0;
    // High to low so the lowest opaque column wins.
    for (int k = opbb_pkg::PixPerRow - 1; k >= 0; k--) begin
      if (opaque[k]) scan_o.first = 3'(k);
    end
    for (int k = 0; k < opbb_pkg::PixPerRow; k++) begin
      if (opaque[k]) scan_o.last = 3'(k);
    end
  end

endmodule

// ===== hdl/opaque_pixel_bounding_box_core.sv =====
// Top level: opaque pixel bounding box of an 8bpp tiled sprite, one tile row per word.
//
//  Channel   | Dir | Signals                               | Word
//  ----------+-----+---------------------------------------+-----------------------------------
//  s_axis    | in  | s_axis_tvalid_i/tready_o/tdata_i      | row_pixels[63:0]
//  m_axis    | out | m_axis_tvalid_o/tready_i/tdata_o      | left,top,width,height,any_opaque
//  cfg       | in  | cfg_we_i, cfg_wdata_i                 | size_code[3:0]
//
// One input word per cycle while the input is not stalled. Stage one registers the row scan
// (opaque flags, first and last opaque column); stage two updates the position counters and
// running min/max and, on the sprite's last tile row, loads the result register. Result valid
// is registered and rises when stage two advances on the sprite's last row. Reset clears
// counters to zero and sets the minima to the 8x8 shape. A stall only holds the input when
// the last row meets a full result register.
module opaque_pixel_bounding_box_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: row_pixels[63:0], byte k = pixel column k
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [opbb_pkg::RowW-1:0]     s_axis_tdata_i,
  // tdata: box_left[5:0], box_top[11:6], box_width[18:12], box_height[25:19],
  //        any_opaque[26], zero[31:27]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [opbb_pkg::OutDataW-1:0] m_axis_tdata_o,
  // size_code register write
  input  logic                          cfg_we_i,
  input  opbb_pkg::size_code_t          cfg_wdata_i
);

  // ---------------- Stage one: row scan register ----------------
  opbb_pkg::row_scan_t scan_c, scan_q;
  logic                scan_v_d, scan_v_q;
  logic                in_acc;
  logic                advance;

  opbb_row_scan u_row_scan (
    .row_i  (s_axis_tdata_i),
    .scan_o (scan_c)
  );

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------- Stage two: sprite state ----------------
  opbb_pkg::size_code_t size_code_d, size_code_q;
  logic [2:0] tile_col_d, tile_col_q;
  logic [2:0] tile_row_d, tile_row_q;
  logic [2:0] row_in_tile_d, row_in_tile_q;
  logic [6:0] min_col_d, min_col_q;
  logic [5:0] max_col_d, max_col_q;
  logic [6:0] min_row_d, min_row_q;
  logic [5:0] max_row_d, max_row_q;

  opbb_pkg::dim_t wdim, hdim, new_wdim, new_hdim;
  logic [3:0] wcnt, hcnt;
  logic       row_end, col_end, trow_end, is_last;
  logic [5:0] ry, rx_min, rx_max;
  logic [6:0] min_col_n, min_row_n;
  logic [5:0] max_col_n, max_row_n;

  assign wdim     = opbb_pkg::sprite_w(size_code_q);
  assign hdim     = opbb_pkg::sprite_h(size_code_q);
  assign new_wdim = opbb_pkg::sprite_w(cfg_wdata_i);
  assign new_hdim = opbb_pkg::sprite_h(cfg_wdata_i);
  assign wcnt     = wdim[6:3];
  assign hcnt     = hdim[6:3];

  assign row_end  = (row_in_tile_q == 3'd7);
  assign col_end  = (({1'b0, tile_col_q} + 4'd1) >= wcnt);
  assign trow_end = (({1'b0, tile_row_q} + 4'd1) >= hcnt);
  assign is_last  = row_end && col_end && trow_end;

  assign ry     = {tile_row_q, row_in_tile_q};
  assign rx_min = {tile_col_q, scan_q.first};
  assign rx_max = {tile_col_q, scan_q.last};

  // Running extremes including the row in stage two.
  always_comb begin
    min_col_n = min_col_q;
    max_col_n = max_col_q;
    min_row_n = min_row_q;
    max_row_n = max_row_q;
    if (scan_q.any) begin
      if ({1'b0, rx_min} < min_col_q) min_col_n = {1'b0, rx_min};
      if (rx_max > max_col_q)         max_col_n = rx_max;
      if ({1'b0, ry} < min_row_q)     min_row_n = {1'b0, ry};
      if (ry > max_row_q)             max_row_n = ry;
    end
  end

  // ---------------- Result register ----------------
  logic       out_v_d, out_v_q;
  logic [5:0] box_left_d, box_left_q;
  logic [5:0] box_top_d, box_top_q;
  logic [6:0] box_width_d, box_width_q;
  logic [6:0] box_height_d, box_height_q;
  logic       any_d, any_q;
  logic       box_ok;

  // Stage two stalls only when it must emit and the result register is still held.
  assign advance         = scan_v_q && (!is_last || !out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !scan_v_q || advance;

  assign box_ok = (min_col_n < wdim) && ({1'b0, max_col_n} >= min_col_n)
               && ({1'b0, max_row_n} >= min_row_n);

  always_comb begin
    if (box_ok) begin
      box_left_d   = min_col_n[5:0];
      box_top_d    = min_row_n[5:0];
      box_width_d  = 7'({1'b0, max_col_n} - min_col_n + 7'd1);
      box_height_d = 7'({1'b0, max_row_n} - min_row_n + 7'd1);
      any_d        = 1'b1;
    end else begin
      box_left_d   = 6'd0;
      box_top_d    = 6'd0;
      box_width_d  = 7'd0;
      box_height_d = 7'd0;
      any_d        = 1'b0;
    end
  end

  // Next state for stage one, sprite state and result valid.
  always_comb begin
    scan_v_d      = scan_v_q;
    size_code_d   = size_code_q;
    tile_col_d    = tile_col_q;
    tile_row_d    = tile_row_q;
    row_in_tile_d = row_in_tile_q;
    min_col_d     = min_col_q;
    max_col_d     = max_col_q;
    min_row_d     = min_row_q;
    max_row_d     = max_row_q;
    out_v_d       = out_v_q;

    if (in_acc) begin
      scan_v_d = 1'b1;
    end else if (advance) begin
      scan_v_d = 1'b0;
    end

    if (out_v_q && m_axis_tready_i) out_v_d = 1'b0;

    if (cfg_we_i) begin
      // New shape restarts the sprite.
      size_code_d   = cfg_wdata_i;
      tile_col_d    = 3'd0;
      tile_row_d    = 3'd0;
      row_in_tile_d = 3'd0;
      min_col_d     = new_wdim;
      max_col_d     = 6'd0;
      min_row_d     = new_hdim;
      max_row_d     = 6'd0;
    end else if (advance) begin
      if (is_last) begin
        out_v_d       = 1'b1;
        tile_col_d    = 3'd0;
        tile_row_d    = 3'd0;
        row_in_tile_d = 3'd0;
        min_col_d     = wdim;
        max_col_d     = 6'd0;
        min_row_d     = hdim;
        max_row_d     = 6'd0;
      end else begin
        min_col_d = min_col_n;
        max_col_d = max_col_n;
        min_row_d = min_row_n;
        max_row_d = max_row_n;
        if (row_end) begin
          row_in_tile_d = 3'd0;
          if (col_end) begin
            tile_col_d = 3'd0;
            tile_row_d = tile_row_q + 3'd1;
          end else begin
            tile_col_d = tile_col_q + 3'd1;
          end
        end else begin
          row_in_tile_d = row_in_tile_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_v_q      <= 1'b0;
      size_code_q   <= '0;
      tile_col_q    <= 3'd0;
      tile_row_q    <= 3'd0;
      row_in_tile_q <= 3'd0;
      min_col_q     <= opbb_pkg::ShapeW[0];
      max_col_q     <= 6'd0;
      min_row_q     <= opbb_pkg::ShapeH[0];
      max_row_q     <= 6'd0;
      out_v_q       <= 1'b0;
    end else begin
      scan_v_q      <= scan_v_d;
      size_code_q   <= size_code_d;
      tile_col_q    <= tile_col_d;
      tile_row_q    <= tile_row_d;
      row_in_tile_q <= row_in_tile_d;
      min_col_q     <= min_col_d;
      max_col_q     <= max_col_d;
      min_row_q     <= min_row_d;
      max_row_q     <= max_row_d;
      out_v_q       <= out_v_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) scan_q <= scan_c;
    if (advance && is_last && !cfg_we_i) begin
      box_left_q   <= box_left_d;
      box_top_q    <= box_top_d;
      box_width_q  <= box_width_d;
      box_height_q <= box_height_d;
      any_q        <= any_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {5'd0, any_q, box_height_q, box_width_q, box_top_q, box_left_q};

endmodule
